@@ design/telemetry_packet_framer_defines.svh @@
// Assertion macros for the telemetry packet framer.
// Included by the top level; no other dependencies.
`ifndef TELEMETRY_PACKET_FRAMER_DEFINES_SVH
`define TELEMETRY_PACKET_FRAMER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TPF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("telemetry_packet_framer: same-cycle check failed");
`define TPF_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("telemetry_packet_framer: next-cycle check failed");
`else
`define TPF_ASSERT_IMP(name, clk, rst, ante, cons)
`define TPF_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

@@ design/tpf_pkg.sv @@
// Shared constants, item kinds, byte slots and the CRC step for the framer.
// No dependencies.
`timescale 1ns / 1ps

package tpf_pkg;

  localparam int APID_W = 9;
  localparam int SEQ_W  = 14;
  localparam int LEN_W  = 12;
  localparam int TC_W   = 40;
  localparam int STEP_W = 5;

  // every 9-bit APID has a counter; the clearing pass sweeps them all
  localparam logic [LEN_W-1:0] APID_COUNT   = 12'd512;
  localparam logic [LEN_W-1:0] MAX_DATA_LEN = 12'd2048;
  localparam logic [LEN_W-1:0] PLEN_BIAS    = 12'd9;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [7:0]  HDR_VERSION = 8'h08;
  localparam logic [7:0]  SEQ_FLAGS   = 8'hC0;
  localparam logic [7:0]  SEC_HDR     = 8'h10;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_ERR   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  // byte slots of a frame
  localparam logic [STEP_W-1:0] STEP_FHDR0   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_FC_A    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_FC_B    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_FHDR3   = 5'd3;
  localparam logic [STEP_W-1:0] STEP_ID_HI   = 5'd4;
  localparam logic [STEP_W-1:0] STEP_ID_LO   = 5'd5;
  localparam logic [STEP_W-1:0] STEP_SEQ_HI  = 5'd6;
  localparam logic [STEP_W-1:0] STEP_SEQ_LO  = 5'd7;
  localparam logic [STEP_W-1:0] STEP_LEN_HI  = 5'd8;
  localparam logic [STEP_W-1:0] STEP_LEN_LO  = 5'd9;
  localparam logic [STEP_W-1:0] STEP_SEC     = 5'd10;
  localparam logic [STEP_W-1:0] STEP_SVC     = 5'd11;
  localparam logic [STEP_W-1:0] STEP_SUB     = 5'd12;
  localparam logic [STEP_W-1:0] STEP_TC4     = 5'd13;
  localparam logic [STEP_W-1:0] STEP_TC3     = 5'd14;
  localparam logic [STEP_W-1:0] STEP_TC2     = 5'd15;
  localparam logic [STEP_W-1:0] STEP_TC1     = 5'd16;
  localparam logic [STEP_W-1:0] STEP_TC0_DAT = 5'd17;
  localparam logic [STEP_W-1:0] STEP_CRC_HI  = 5'd18;
  localparam logic [STEP_W-1:0] STEP_CRC_LO  = 5'd19;
  localparam logic [STEP_W-1:0] STEP_STATUS  = 5'd20;

  // CRC-16-CCITT, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = b[7-k] ^ c[15];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

@@ design/tpf_ifs.sv @@
// Valid/ready channel interfaces for framer items and framed bytes.
// Depends on tpf_pkg for field widths.
`timescale 1ns / 1ps

interface tpf_item_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [tpf_pkg::APID_W-1:0]  apid;
  logic [tpf_pkg::LEN_W-1:0]   data_length;
  logic [7:0]                  service_type;
  logic [7:0]                  service_subtype;
  logic [tpf_pkg::TC_W-1:0]    time_code;
  logic [1:0]                  command_count;
  logic [7:0]                  data_byte;

  modport source (output valid, func, apid, data_length, service_type, service_subtype,
                  time_code, command_count, data_byte, input ready);
  modport sink   (input valid, func, apid, data_length, service_type, service_subtype,
                  time_code, command_count, data_byte, output ready);
endinterface

interface tpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

@@ design/telemetry_packet_framer.sv @@
// An item is loaded into the working-item registers on transfer; its bytes then pass through
// the output register, one framed byte per cycle while the output is not stalled. A data
// item emits its byte (then CRC and status when it closes the packet), a start item the
// header bytes (then CRC and status if empty), a rejected start one error byte, and a data
// item outside a packet is taken but emits nothing. Reset (rst, synchronous): clears control
// state; a pass then zeroes all 512 per-APID counters, holding off items until it completes.
`timescale 1ns / 1ps
`include "telemetry_packet_framer_defines.svh"

module telemetry_packet_framer (
  input  logic        clk,
  input  logic        rst,
  tpf_item_if.sink    items,
  tpf_byte_if.source  frame
);

  localparam int SEQ_DEPTH = 1 << tpf_pkg::APID_W;

  // sequence counter memory and clearing sweep
  logic [tpf_pkg::SEQ_W-1:0]  seq_mem [0:SEQ_DEPTH-1];
  logic [tpf_pkg::SEQ_W-1:0]  seq_rdata;
  logic                       seq_we;
  logic [tpf_pkg::APID_W-1:0] seq_waddr;
  logic [tpf_pkg::SEQ_W-1:0]  seq_wdata;
  logic [tpf_pkg::APID_W:0]   clr_cnt;
  logic                       clearing;

  // packet state, updated as items transfer
  logic                       in_packet;
  logic [tpf_pkg::LEN_W-1:0]  bytes_remaining;
  logic [tpf_pkg::APID_W-1:0] current_apid;
  logic [1:0]                 latched_count;
  logic [7:0]                 frame_counter;
  logic [15:0]                crc;

  // working item
  logic                        work_valid;
  logic [1:0]                  work_kind;
  logic [tpf_pkg::STEP_W-1:0]  work_step;
  logic                        work_fin;
  logic [tpf_pkg::APID_W-1:0]  work_apid;
  logic [tpf_pkg::LEN_W-1:0]   work_plen;
  logic [7:0]                  work_st;
  logic [7:0]                  work_sst;
  logic [tpf_pkg::TC_W-1:0]    work_tc;
  logic [7:0]                  work_dbyte;

  logic                        in_fire;
  logic                        start_bad;
  logic [1:0]                  in_kind;
  logic                        in_fin;
  logic                        load;
  logic                        emit;
  logic                        work_last;
  logic [7:0]                  byte_sel;
  logic                        crc_take;
  logic                        status_emit;
  logic                        start_fire;
  logic                        at_fhdr0;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  assign clearing  = !clr_cnt[tpf_pkg::APID_W];
  assign emit      = work_valid && (!out_valid || frame.ready);
  assign work_last = (work_kind == tpf_pkg::KIND_ERR) || (work_step == tpf_pkg::STEP_STATUS)
                     || (work_step == tpf_pkg::STEP_TC0_DAT && !work_fin);
  assign items.ready = !clearing && (!work_valid || (emit && work_last));
  assign in_fire     = items.valid && items.ready;

  assign start_bad = (items.data_length > tpf_pkg::MAX_DATA_LEN)
                     || ({3'b000, items.apid} >= tpf_pkg::APID_COUNT);

  always_comb begin
    if (items.func == tpf_pkg::FUNC_START) begin
      in_kind = start_bad ? tpf_pkg::KIND_ERR : tpf_pkg::KIND_START;
      in_fin  = !start_bad && (items.data_length == '0);
    end else begin
      in_kind = tpf_pkg::KIND_DATA;
      in_fin  = (bytes_remaining == tpf_pkg::LEN_W'(1));
    end
  end

  // a data item outside a packet is taken and dropped
  assign load = in_fire && ((items.func == tpf_pkg::FUNC_START) || in_packet);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet       <= 1'b0;
      bytes_remaining <= '0;
      current_apid    <= '0;
      latched_count   <= '0;
    end else if (in_fire) begin
      if (in_kind == tpf_pkg::KIND_START) begin
        in_packet       <= !in_fin;
        bytes_remaining <= items.data_length;
        current_apid    <= items.apid;
        latched_count   <= items.command_count;
      end else if (in_kind == tpf_pkg::KIND_ERR) begin
        in_packet <= 1'b0;
      end else if (in_packet) begin
        bytes_remaining <= bytes_remaining - tpf_pkg::LEN_W'(1);
        if (in_fin) begin
          in_packet <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      work_kind  <= tpf_pkg::KIND_START;
      work_step  <= tpf_pkg::STEP_FHDR0;
      work_fin   <= 1'b0;
    end else begin
      work_valid <= load || (work_valid && !(emit && work_last));
      if (load) begin
        work_kind <= in_kind;
        work_fin  <= in_fin;
        work_step <= (in_kind == tpf_pkg::KIND_DATA) ? tpf_pkg::STEP_TC0_DAT
                                                     : tpf_pkg::STEP_FHDR0;
      end else if (emit && !work_last) begin
        work_step <= work_step + tpf_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work_apid  <= items.apid;
      work_plen  <= items.data_length + tpf_pkg::PLEN_BIAS;
      work_st    <= items.service_type;
      work_sst   <= items.service_subtype;
      work_tc    <= items.time_code;
      work_dbyte <= items.data_byte;
    end
  end

  always_comb begin
    case (work_step)
      tpf_pkg::STEP_FHDR0:   byte_sel = 8'h00;
      tpf_pkg::STEP_FC_A:    byte_sel = frame_counter;
      tpf_pkg::STEP_FC_B:    byte_sel = frame_counter;
      tpf_pkg::STEP_FHDR3:   byte_sel = 8'h00;
      tpf_pkg::STEP_ID_HI:   byte_sel = tpf_pkg::HDR_VERSION | {7'b0, work_apid[8]};
      tpf_pkg::STEP_ID_LO:   byte_sel = work_apid[7:0];
      tpf_pkg::STEP_SEQ_HI:  byte_sel = tpf_pkg::SEQ_FLAGS | {2'b00, seq_rdata[13:8]};
      tpf_pkg::STEP_SEQ_LO:  byte_sel = seq_rdata[7:0];
      tpf_pkg::STEP_LEN_HI:  byte_sel = {4'h0, work_plen[11:8]};
      tpf_pkg::STEP_LEN_LO:  byte_sel = work_plen[7:0];
      tpf_pkg::STEP_SEC:     byte_sel = tpf_pkg::SEC_HDR;
      tpf_pkg::STEP_SVC:     byte_sel = work_st;
      tpf_pkg::STEP_SUB:     byte_sel = work_sst;
      tpf_pkg::STEP_TC4:     byte_sel = work_tc[39:32];
      tpf_pkg::STEP_TC3:     byte_sel = work_tc[31:24];
      tpf_pkg::STEP_TC2:     byte_sel = work_tc[23:16];
      tpf_pkg::STEP_TC1:     byte_sel = work_tc[15:8];
      tpf_pkg::STEP_TC0_DAT: byte_sel = (work_kind == tpf_pkg::KIND_DATA) ? work_dbyte
                                                                        : work_tc[7:0];
      tpf_pkg::STEP_CRC_HI:  byte_sel = crc[15:8];
      tpf_pkg::STEP_CRC_LO:  byte_sel = crc[7:0];
      tpf_pkg::STEP_STATUS:  byte_sel = {6'b0, latched_count};
      default:               byte_sel = 8'h00;
    endcase
  end

  assign crc_take = ((work_kind == tpf_pkg::KIND_START) && (work_step >= tpf_pkg::STEP_ID_HI)
                     && (work_step <= tpf_pkg::STEP_TC0_DAT))
                    || ((work_kind == tpf_pkg::KIND_DATA) && (work_step == tpf_pkg::STEP_TC0_DAT));

  always_ff @(posedge clk) begin
    if (rst) begin
      crc           <= tpf_pkg::CRC_INIT;
      frame_counter <= '0;
    end else if (emit) begin
      // restart the CRC on every start, valid or not
      if (work_kind != tpf_pkg::KIND_DATA && work_step == tpf_pkg::STEP_FHDR0) begin
        crc <= tpf_pkg::CRC_INIT;
      end else if (crc_take) begin
        crc <= tpf_pkg::crc16_byte(crc, byte_sel);
      end
      if (work_step == tpf_pkg::STEP_STATUS) begin
        frame_counter <= frame_counter + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !frame.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= byte_sel;
      out_last  <= (work_step == tpf_pkg::STEP_STATUS);
      out_error <= (work_kind == tpf_pkg::KIND_ERR);
    end
  end

  assign frame.valid    = out_valid;
  assign frame.out_byte = out_byte;
  assign frame.last     = out_last;
  assign frame.error    = out_error;

  // sequence counters: sweep to zero after reset, bump on packet close
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + (tpf_pkg::APID_W + 1)'(1);
    end
  end

  always_comb begin
    if (clearing) begin
      seq_we    = 1'b1;
      seq_waddr = clr_cnt[tpf_pkg::APID_W-1:0];
      seq_wdata = '0;
    end else begin
      seq_we    = emit && work_fin && (work_step == tpf_pkg::STEP_CRC_HI);
      seq_waddr = current_apid;
      seq_wdata = seq_rdata + tpf_pkg::SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[seq_waddr] <= seq_wdata;
    end
    // read once per start; the value stays put for the whole packet
    if (in_fire && items.func == tpf_pkg::FUNC_START) begin
      seq_rdata <= seq_mem[items.apid];
    end
  end

  assign status_emit = emit && (work_step == tpf_pkg::STEP_STATUS);
  assign start_fire  = in_fire && (in_kind == tpf_pkg::KIND_START);
  assign at_fhdr0    = work_valid && (work_step == tpf_pkg::STEP_FHDR0);

  `TPF_ASSERT_IMP(a_close_clears_packet, clk, rst, status_emit, !in_packet)
  `TPF_ASSERT_NXT(a_start_loads_header, clk, rst, start_fire, at_fhdr0)
  `TPF_ASSERT_IMP(a_idle_while_clearing, clk, rst, clearing, !work_valid && !out_valid)

endmodule

@@ test/tpf_frame_checker.sv @@
// Scoreboard for the telemetry packet framer: follows item transfers, predicts the
// framed byte stream and compares each output transfer with it.
// Depends on tpf_pkg and the channel interfaces in tpf_ifs.sv.
`timescale 1ns / 1ps

module tpf_frame_checker (
  input  logic clk,
  input  logic rst,
  tpf_item_if  items,
  tpf_byte_if  frame,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  import tpf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
  } framed_t;

  framed_t           framed_q[$];
  logic [SEQ_W-1:0]  seq_count [1 << APID_W];
  logic [7:0]        frame_no;
  logic [15:0]       crc;
  logic [LEN_W-1:0]  left;
  logic [APID_W-1:0] in_apid;
  logic [1:0]        in_cmd;
  logic              in_frame;

  function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {d, 8'h00};
    repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] d, input logic fin, input logic err);
    framed_q.push_back({d, fin, err});
  endfunction

  function automatic void push_summed(input logic [7:0] d);
    crc = crc_next(crc, d);
    push_byte(d, 1'b0, 1'b0);
  endfunction

  // CRC high, CRC low, status; then advance both counters
  function automatic void close_frame();
    push_byte(crc[15:8], 1'b0, 1'b0);
    push_byte(crc[7:0], 1'b0, 1'b0);
    push_byte({6'b0, in_cmd}, 1'b1, 1'b0);
    seq_count[in_apid] = seq_count[in_apid] + 1'b1;
    frame_no = frame_no + 8'd1;
    crc = CRC_INIT;
    in_frame = 1'b0;
  endfunction

  always @(posedge clk) begin
    framed_t          want;
    logic [SEQ_W-1:0] seq;
    logic [15:0]      plen;
    if (rst) begin
      foreach (seq_count[i]) seq_count[i] = '0;
      framed_q.delete();
      frame_no   = '0;
      crc        = CRC_INIT;
      left       = '0;
      in_apid    = '0;
      in_cmd     = '0;
      in_frame   = 1'b0;
      fail_count = 0;
      checked    = 0;
    end else begin
      if (items.valid && items.ready) begin
        if (items.func == FUNC_START) begin
          // a start always abandons whatever frame is open
          in_frame = 1'b0;
          crc      = CRC_INIT;
          if (items.data_length > MAX_DATA_LEN) begin
            push_byte(8'h00, 1'b0, 1'b1);
          end else begin
            in_apid = items.apid;
            in_cmd  = items.command_count;
            left    = items.data_length;
            seq     = seq_count[items.apid];
            plen    = {4'b0, items.data_length} + {4'b0, PLEN_BIAS};
            push_byte(8'h00, 1'b0, 1'b0);
            push_byte(frame_no, 1'b0, 1'b0);
            push_byte(frame_no, 1'b0, 1'b0);
            push_byte(8'h00, 1'b0, 1'b0);
            push_summed(HDR_VERSION | {7'b0, items.apid[8]});
            push_summed(items.apid[7:0]);
            push_summed(SEQ_FLAGS | {2'b0, seq[13:8]});
            push_summed(seq[7:0]);
            push_summed(plen[15:8]);
            push_summed(plen[7:0]);
            push_summed(SEC_HDR);
            push_summed(items.service_type);
            push_summed(items.service_subtype);
            for (int k = 4; k >= 0; k--) push_summed(items.time_code[8*k +: 8]);
            in_frame = 1'b1;
            if (left == '0) close_frame();
          end
        end else if (in_frame) begin
          push_summed(items.data_byte);
          left = left - 1'b1;
          if (left == '0) close_frame();
        end
      end
      if (frame.valid && frame.ready) begin
        if (framed_q.size() == 0) begin
          $error("unexpected framed byte %h (last %b, error %b)",
                 frame.out_byte, frame.last, frame.error);
          fail_count++;
        end else begin
          want = framed_q.pop_front();
          checked++;
          if (frame.out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, frame.out_byte);
            fail_count++;
          end
          if (frame.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, frame.last);
            fail_count++;
          end
          if (frame.error !== want.error) begin
            $error("error: expected %b, got %b", want.error, frame.error);
            fail_count++;
          end
        end
      end
    end
    pending = framed_q.size();
  end

endmodule

@@ test/tb.sv @@
// Top of the framer testbench: clock, reset, item stimulus, output back-pressure
// and the verdict. Depends on tpf_pkg, tpf_ifs.sv, the framer and tpf_frame_checker.
`timescale 1ns / 1ps

module tb;
  import tpf_pkg::*;

  localparam int RUN_LIMIT    = 200_000;
  localparam int DRAIN_LIMIT  = 20_000;
  localparam int RANDOM_ITEMS = 450;
  localparam int SOAK_APID    = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          cycles = 0;
  int          sent = 0;
  int          packets = 0;
  int          rejected = 0;
  int          stuck = 0;
  int unsigned left = 0;
  bit          steady = 1'b0;
  int          fail_count;
  int          pending;
  int          checked;

  tpf_item_if items();
  tpf_byte_if frame();

  telemetry_packet_framer u_dut (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .frame (frame)
  );

  tpf_frame_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .frame      (frame),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    frame.ready <= steady || ($urandom_range(99) >= 14);
  end

  function automatic logic [TC_W-1:0] random_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TC_W-1:0];
  endfunction

  // present one item, with random idle cycles ahead of it unless steady, and hold it until transfer
  task automatic hand_over(input logic f, input logic [APID_W-1:0] id,
                           input logic [LEN_W-1:0] len, input logic [7:0] svc,
                           input logic [7:0] sub, input logic [TC_W-1:0] tc,
                           input logic [1:0] cmd, input logic [7:0] payload);
    if (!steady) begin
      while ($urandom_range(99) < 14) begin
        items.valid <= 1'b0;
        @(posedge clk);
      end
    end
    items.valid           <= 1'b1;
    items.func            <= f;
    items.apid            <= id;
    items.data_length     <= len;
    items.service_type    <= svc;
    items.service_subtype <= sub;
    items.time_code       <= tc;
    items.command_count   <= cmd;
    items.data_byte       <= payload;
    do @(posedge clk); while (items.ready !== 1'b1);
  endtask

  task automatic send_start(input logic [APID_W-1:0] id, input logic [LEN_W-1:0] len,
                            input logic [7:0] svc, input logic [7:0] sub,
                            input logic [TC_W-1:0] tc, input logic [1:0] cmd);
    hand_over(FUNC_START, id, len, svc, sub, tc, cmd, 8'($urandom));
    sent++;
    if (len > MAX_DATA_LEN) begin
      rejected++;
      left = 0;
    end else begin
      packets++;
      left = int'(len);
    end
  endtask

  task automatic start_random(input logic [APID_W-1:0] id, input logic [LEN_W-1:0] len);
    send_start(id, len, 8'($urandom), 8'($urandom), random_time(), 2'($urandom));
  endtask

  // start-only fields carry noise on data items
  task automatic send_data(input logic [7:0] payload);
    hand_over(FUNC_DATA, 9'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
              random_time(), 2'($urandom), payload);
    if (left > 0) begin
      sent++;
      left--;
    end
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending != 0) begin
      $error("%0d framed bytes never arrived", pending);
      stuck++;
    end
  endtask

  initial begin
    int                base;
    int                pick;
    logic [APID_W-1:0] id;
    logic [LEN_W-1:0]  len;

    items.valid           = 1'b0;
    items.func            = FUNC_START;
    items.apid            = '0;
    items.data_length     = '0;
    items.service_type    = '0;
    items.service_subtype = '0;
    items.time_code       = '0;
    items.command_count   = '0;
    items.data_byte       = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty packets with all-zero and all-one header fields
    send_start('0, '0, 8'h00, 8'h00, '0, 2'd0);
    send_start('1, '0, 8'hFF, 8'hFF, '1, 2'd3);
    // lengths past the limit: single error byte
    start_random(9'($urandom), MAX_DATA_LEN + 12'd1);
    start_random(9'($urandom), '1);
    start_random(9'd5, 12'd3);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hA5);
    send_data(8'h3C);            // nothing open: dropped
    // longest legal length, abandoned by a new start
    start_random(9'd5, MAX_DATA_LEN);
    send_data(8'h11);
    send_data(8'h22);
    start_random(9'd7, 12'd1);
    send_data(8'h80);
    // open packet abandoned by a rejected start; following byte is dropped
    start_random(9'd9, 12'd4);
    send_data(8'h55);
    send_data(8'hAA);
    start_random(9'd9, 12'd3000);
    send_data(8'h01);
    start_random(9'd1, 12'd1);
    send_data(8'hFF);
    wait_idle();

    // long stretch without idling: the first random items
    steady = 1'b1;

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      if (sent - base > 150) steady = 1'b0;
      id   = ($urandom_range(3) == 0) ? 9'($urandom) : 9'(SOAK_APID + $urandom_range(3));
      pick = $urandom_range(99);
      case ($urandom_range(99)) inside
        [0:39]:  len = '0;
        [40:84]: len = 12'($urandom_range(1, 8));
        default: len = 12'($urandom_range(9, 24));
      endcase
      if (pick < 70) begin
        start_random(id, len);
        repeat (int'(len)) send_data(8'($urandom));
      end else if (pick < 80) begin
        // cut short; the next start abandons it
        len = 12'($urandom_range(2, 20));
        start_random(id, len);
        repeat ($urandom_range(1, int'(len) - 1)) send_data(8'($urandom));
      end else if (pick < 90) begin
        start_random(id, 12'($urandom_range(int'(MAX_DATA_LEN) + 1, 4095)));
      end else begin
        repeat ($urandom_range(1, 3)) send_data(8'($urandom));
      end
    end

    wait_idle();
    repeat (30) @(posedge clk);

    $display("run: %0d items, %0d packets opened, %0d starts rejected, %0d bytes compared",
             sent, packets, rejected, checked);
    $display("run: header extremes, abandoned packets, a %0d-byte start, stray data bytes",
             MAX_DATA_LEN);
    if (fail_count == 0 && stuck == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
